@@ rtl/core/bgd_pkg.sv @@
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants of the button gesture detector: gesture codes,
// register indexes, the configuration set and the per-button state word.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int COUNT_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [2:0] {
    G_SHORT  = 3'd0,
    G_LONG   = 3'd1,
    G_DOUBLE = 3'd2,
    G_HOLD   = 3'd3,
    G_REPEAT = 3'd4
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOUBLE_WINDOW = 3'd0,
    REG_LONG_PRESS    = 3'd1,
    REG_HOLD_PRESS    = 3'd2,
    REG_REPEAT_PERIOD = 3'd3,
    REG_DOUBLE_HOLD   = 3'd4,
    REG_TWO_STAGE     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic [15:0] double_window_ms;
    logic [15:0] long_press_ms;
    logic [15:0] hold_press_ms;
    logic [15:0] repeat_period_ms;
    logic [7:0]  double_hold_enable;
    logic [7:0]  two_stage_enable;
  } cfg_regs_t;

  typedef struct packed {
    logic        btn_down;
    logic        long_sent;
    logic        hold_sent;
    logic        tap_waiting;
    logic        press_eaten;
    logic [31:0] press_stamp;
    logic [31:0] repeat_stamp;
    logic [31:0] tap_stamp;
  } btn_state_t;

  typedef struct packed {
    logic     fire;
    gesture_t kind;
  } eval_res_t;

  // Buttons from index 8 upwards have no mask bit and stay in normal mode.
  function automatic logic mask_bit(logic [7:0] mask, logic [3:0] idx);
    logic bit_val;
    bit_val = 1'b0;
    if (!idx[3]) begin
      bit_val = mask[idx[2:0]];
    end
    return bit_val;
  endfunction

endpackage

@@ rtl/core/bgd_ram.sv @@
// ----------------------------------------------------------------------------
// bgd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module bgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bgd_eval.sv @@
// ----------------------------------------------------------------------------
// bgd_eval
// Gesture rules for one button: takes the stored state word and the current
// request, and gives the updated word and at most one gesture.
// ----------------------------------------------------------------------------
module bgd_eval
  import bgd_pkg::*;
(
  input  cfg_regs_t   cfg,
  input  btn_state_t  cur_state,
  input  logic        dh_mode,
  input  logic        ts_mode,
  input  logic        is_tick,
  input  logic        pressed,
  input  logic [31:0] now,
  output btn_state_t  next_state,
  output eval_res_t   res
);

  logic [31:0] d_press;
  logic [31:0] d_tap;
  logic [31:0] d_repeat;
  logic        hold_due;
  logic        long_due;
  logic        repeat_due;
  logic        tap_inside;

  // Differences wrap modulo 2^32, as the time counter does.
  assign d_press    = now - cur_state.press_stamp;
  assign d_tap      = now - cur_state.tap_stamp;
  assign d_repeat   = now - cur_state.repeat_stamp;
  assign hold_due   = d_press >= {16'd0, cfg.hold_press_ms};
  assign long_due   = d_press >= {16'd0, cfg.long_press_ms};
  assign repeat_due = d_repeat >= {16'd0, cfg.repeat_period_ms};
  assign tap_inside = d_tap <= {16'd0, cfg.double_window_ms};

  always_comb begin
    next_state = cur_state;
    res.fire   = 1'b0;
    res.kind   = G_SHORT;
    if (!is_tick) begin
      if (dh_mode) begin
        if (pressed) begin
          if (cur_state.tap_waiting && tap_inside) begin
            next_state.tap_waiting = 1'b0;
            next_state.press_eaten = 1'b1;
            res.fire               = 1'b1;
            res.kind               = G_DOUBLE;
          end else begin
            next_state.press_eaten = 1'b0;
          end
          next_state.btn_down    = 1'b1;
          next_state.press_stamp = now;
          next_state.hold_sent   = 1'b0;
        end else if (cur_state.btn_down) begin
          if (!cur_state.hold_sent && !cur_state.press_eaten) begin
            next_state.tap_waiting = 1'b1;
            next_state.tap_stamp   = now;
          end
          next_state.btn_down    = 1'b0;
          next_state.hold_sent   = 1'b0;
          next_state.press_eaten = 1'b0;
        end
      end else if (pressed) begin
        next_state.press_stamp  = now;
        next_state.btn_down     = 1'b1;
        next_state.long_sent    = 1'b0;
        next_state.hold_sent    = 1'b0;
        next_state.repeat_stamp = '0;
      end else begin
        if (cur_state.btn_down) begin
          if (ts_mode) begin
            if (!cur_state.hold_sent) begin
              res.fire = 1'b1;
              res.kind = long_due ? G_LONG : G_SHORT;
            end
          end else if (!cur_state.long_sent) begin
            res.fire = 1'b1;
            res.kind = G_SHORT;
          end
        end
        next_state.btn_down  = 1'b0;
        next_state.long_sent = 1'b0;
        next_state.hold_sent = 1'b0;
      end
    end else begin
      if (dh_mode) begin
        // A Hold clears the waiting tap, so at most one of the two fires.
        if (cur_state.btn_down && !cur_state.hold_sent && hold_due) begin
          next_state.hold_sent   = 1'b1;
          next_state.tap_waiting = 1'b0;
          res.fire               = 1'b1;
          res.kind               = G_HOLD;
        end else if (cur_state.tap_waiting && !tap_inside) begin
          next_state.tap_waiting = 1'b0;
          res.fire               = 1'b1;
          res.kind               = G_SHORT;
        end
      end else if (cur_state.btn_down) begin
        if (ts_mode) begin
          if (!cur_state.hold_sent && hold_due) begin
            next_state.hold_sent = 1'b1;
            res.fire             = 1'b1;
            res.kind             = G_HOLD;
          end
        end else if (!cur_state.long_sent) begin
          if (long_due) begin
            next_state.long_sent    = 1'b1;
            next_state.repeat_stamp = now;
            res.fire                = 1'b1;
            res.kind                = G_LONG;
          end
        end else if (repeat_due) begin
          next_state.repeat_stamp = now;
          res.fire                = 1'b1;
          res.kind                = G_REPEAT;
        end
      end
    end
  end

endmodule

@@ rtl/core/button_gesture_detector_top.sv @@
// ----------------------------------------------------------------------------
// button_gesture_detector_top
// Per-button tap, double, long, hold and repeat detector. Button state is
// held in one RAM word per button and updated by read, modify and write.
// ----------------------------------------------------------------------------
// An edge request reads the state word of its button at acceptance, then
// evaluates it and writes it back. A tick request visits one button per
// cycle through the single RAM read port, unless a held gesture waits on a
// stalled output. Requests are taken one at a time. Reset sets the control
// and configuration registers to their defaults and marks every RAM entry
// invalid, so unwritten entries read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_gesture_detector_top
  import bgd_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // requests
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [2:0]            button_id,
  input  logic                  key_pressed,
  input  logic [31:0]           timestamp,
  // gestures
  output logic                  gesture_valid,
  input  logic                  gesture_stall,
  output logic [2:0]            gesture_button,
  output logic [2:0]            gesture_kind,
  output logic [31:0]           event_stamp,
  output logic                  last_of_run
);

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_regs_t   cfg;
  ctrl_state_t state;
  ctrl_state_t state_next;

  logic             item_tick;
  logic             item_pressed;
  logic [31:0]      item_stamp;
  logic [AW-1:0]    cur;
  logic [COUNT_W-1:0] count;
  logic             rd_pending;
  logic             rd_valid;
  logic [NUM_BUTTONS-1:0] entry_valid;

  logic             pend_valid;
  logic [2:0]       pend_button;
  gesture_t         pend_kind;

  logic             accept;
  logic             id_ok;
  logic [3:0]       id4;
  logic [3:0]       cur4;
  logic             out_free;
  logic             step;
  logic             last_btn;
  logic             keep;
  logic             flush_go;
  logic             rd_en;
  logic [AW-1:0]    raddr;
  logic [$bits(btn_state_t)-1:0] ram_rdata;
  btn_state_t       cur_state;
  btn_state_t       next_state;
  eval_res_t        res;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign id4        = {1'b0, button_id};
  assign id_ok      = {2'b00, button_id} < 5'(NUM_BUTTONS);
  assign cur4       = 4'(cur);
  assign out_free   = !gesture_valid || !gesture_stall;
  assign step       = (state == ST_SCAN) && rd_pending && (!pend_valid || out_free);
  assign last_btn   = !item_tick || (cur == AW'(NUM_BUTTONS - 1));
  assign keep       = step && res.fire && (count < COUNT_W'(MAX_RESULTS));
  assign flush_go   = (state == ST_FLUSH) && pend_valid && out_free;

  // Read port: first button at acceptance, then the next one while a tick
  // scan is stepping. Different entries, so no forwarding is needed.
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    if (accept && (mode || id_ok)) begin
      rd_en = 1'b1;
      raddr = mode ? '0 : id4[AW-1:0];
    end else if (step && !last_btn) begin
      rd_en = 1'b1;
      raddr = cur + AW'(1);
    end
  end

  bgd_ram #(
    .WIDTH ($bits(btn_state_t)),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (step),
    .waddr (cur),
    .wdata (next_state),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign cur_state = rd_valid ? btn_state_t'(ram_rdata) : '0;

  bgd_eval u_eval (
    .cfg        (cfg),
    .cur_state  (cur_state),
    .dh_mode    (mask_bit(cfg.double_hold_enable, cur4)),
    .ts_mode    (mask_bit(cfg.two_stage_enable, cur4)),
    .is_tick    (item_tick),
    .pressed    (item_pressed),
    .now        (item_stamp),
    .next_state (next_state),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_window_ms   <= 16'd300;
      cfg.long_press_ms      <= 16'd800;
      cfg.hold_press_ms      <= 16'd1500;
      cfg.repeat_period_ms   <= 16'd200;
      cfg.double_hold_enable <= '0;
      cfg.two_stage_enable   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DOUBLE_WINDOW: cfg.double_window_ms   <= cfg_data;
        REG_LONG_PRESS:    cfg.long_press_ms      <= cfg_data;
        REG_HOLD_PRESS:    cfg.hold_press_ms      <= cfg_data;
        REG_REPEAT_PERIOD: cfg.repeat_period_ms   <= cfg_data;
        REG_DOUBLE_HOLD:   cfg.double_hold_enable <= cfg_data[7:0];
        REG_TWO_STAGE:     cfg.two_stage_enable   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (mode || id_ok) ? ST_SCAN : ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (step && last_btn) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state of the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending  <= 1'b0;
      rd_valid    <= 1'b0;
      entry_valid <= '0;
      count       <= '0;
      pend_valid  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_valid   <= entry_valid[raddr];
        rd_pending <= 1'b1;
      end else if (step) begin
        rd_pending <= 1'b0;
      end
      if (step) begin
        entry_valid[cur] <= 1'b1;
      end
      if (accept) begin
        count <= '0;
      end else if (keep) begin
        count <= count + COUNT_W'(1);
      end
      if (keep) begin
        pend_valid <= 1'b1;
      end else if (flush_go) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_tick    <= mode;
      item_pressed <= key_pressed;
      item_stamp   <= timestamp;
      cur          <= mode ? '0 : id4[AW-1:0];
    end else if (step && !last_btn) begin
      cur <= cur + AW'(1);
    end
    if (keep) begin
      pend_button <= cur4[2:0];
      pend_kind   <= res.kind;
    end
  end

  // A held gesture goes out once the next one arrives (not last) or at the
  // end of the request (last).
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_valid <= 1'b0;
    end else if ((keep && pend_valid) || flush_go) begin
      gesture_valid <= 1'b1;
    end else if (!gesture_stall) begin
      gesture_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((keep && pend_valid) || flush_go) begin
      gesture_button <= pend_button;
      gesture_kind   <= pend_kind;
      event_stamp    <= item_stamp;
      last_of_run    <= flush_go;
    end
  end

endmodule

@@ rtl/core/bgd_checker.sv @@
// ----------------------------------------------------------------------------
// bgd_checker
// Port-level checks of the gesture detector, bound to the top level.
// ----------------------------------------------------------------------------
module bgd_checker
  import bgd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data,
  input logic                  item_valid,
  input logic                  item_stall,
  input logic                  mode,
  input logic [2:0]            button_id,
  input logic                  key_pressed,
  input logic [31:0]           timestamp,
  input logic                  gesture_valid,
  input logic                  gesture_stall,
  input logic [2:0]            gesture_button,
  input logic [2:0]            gesture_kind,
  input logic [31:0]           event_stamp,
  input logic                  last_of_run
);

  // A stalled gesture stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    gesture_valid && gesture_stall |=> gesture_valid && $stable(gesture_button)
      && $stable(gesture_kind) && $stable(event_stamp) && $stable(last_of_run))
    else $error("stalled gesture changed");

  // Requests are worked one at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second request taken while busy");

  // Gestures are only produced by a request in progress.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !item_stall && !gesture_valid |=> !gesture_valid)
    else $error("gesture appeared while idle");

  // A gesture that is not the last of its run leaves the request unfinished.
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    gesture_valid && !gesture_stall && !last_of_run |-> item_stall)
    else $error("run ended without a last gesture");

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (.*);

@@ tb/sv/button_gesture_detector_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_gesture_detector_top_test
// Self-checking bench for the button gesture detector. A scoreboard keeps
// its own copy of the per-button state and registers, predicts the gestures
// of every accepted request and checks them in order against the block's
// output. Directed requests cover the corner cases; random phases follow
// under several register settings, with random gaps, stalls and a long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module button_gesture_detector_top_test;
  import bgd_pkg::*;

  localparam int   N_BUTTONS       = 8;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam logic MODE_EDGE       = 1'b0;
  localparam logic MODE_TICK       = 1'b1;

  typedef struct {
    logic [2:0]  button;
    gesture_t    kind;
    logic [31:0] stamp;
    logic        last;
  } gesture_rec_t;

  class gesture_scoreboard;
    logic [15:0]  double_window, long_press, hold_press, repeat_period;
    logic [7:0]   double_hold_mask, two_stage_mask;
    bit           down[N_BUTTONS];
    bit           long_done[N_BUTTONS];
    bit           hold_done[N_BUTTONS];
    bit           tap_open[N_BUTTONS];
    bit           eaten[N_BUTTONS];
    logic [31:0]  press_at[N_BUTTONS];
    logic [31:0]  repeat_at[N_BUTTONS];
    logic [31:0]  tap_at[N_BUTTONS];
    gesture_rec_t run_q[$];
    gesture_rec_t pending_gestures[$];
    int           errors, checked, requests, ticks;
    int           kind_count[5];

    function new();
      double_window    = 16'd300;
      long_press       = 16'd800;
      hold_press       = 16'd1500;
      repeat_period    = 16'd200;
      double_hold_mask = 8'h00;
      two_stage_mask   = 8'h00;
      for (int b = 0; b < N_BUTTONS; b++) begin
        down[b]      = 1'b0;
        long_done[b] = 1'b0;
        hold_done[b] = 1'b0;
        tap_open[b]  = 1'b0;
        eaten[b]     = 1'b0;
        press_at[b]  = '0;
        repeat_at[b] = '0;
        tap_at[b]    = '0;
      end
      errors   = 0;
      checked  = 0;
      requests = 0;
      ticks    = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      case (idx)
        REG_DOUBLE_WINDOW: double_window    = val;
        REG_LONG_PRESS:    long_press       = val;
        REG_HOLD_PRESS:    hold_press       = val;
        REG_REPEAT_PERIOD: repeat_period    = val;
        REG_DOUBLE_HOLD:   double_hold_mask = val[7:0];
        REG_TWO_STAGE:     two_stage_mask   = val[7:0];
        default: ;
      endcase
    endfunction

    // Buttons beyond the mask width always run in normal mode.
    function bit mode_bit(logic [7:0] mask, int b);
      if (b >= 8) return 1'b0;
      return mask[b];
    endfunction

    function void add_gesture(int b, gesture_t k, logic [31:0] now);
      gesture_rec_t g;
      if (run_q.size() >= MAX_RESULTS) return;
      g.button = 3'(b);
      g.kind   = k;
      g.stamp  = now;
      g.last   = 1'b0;
      run_q.push_back(g);
    endfunction

    function void press_edge(int b, logic pressed, logic [31:0] now);
      logic [31:0] dt;
      if (mode_bit(double_hold_mask, b)) begin
        if (pressed) begin
          dt = now - tap_at[b];
          if (tap_open[b] && dt <= double_window) begin
            tap_open[b] = 1'b0;
            eaten[b]    = 1'b1;
            add_gesture(b, G_DOUBLE, now);
          end else begin
            eaten[b] = 1'b0;
          end
          down[b]      = 1'b1;
          press_at[b]  = now;
          hold_done[b] = 1'b0;
        end else if (down[b]) begin
          if (!hold_done[b] && !eaten[b]) begin
            tap_open[b] = 1'b1;
            tap_at[b]   = now;
          end
          down[b]      = 1'b0;
          hold_done[b] = 1'b0;
          eaten[b]     = 1'b0;
        end
        return;
      end
      if (pressed) begin
        press_at[b]  = now;
        down[b]      = 1'b1;
        long_done[b] = 1'b0;
        hold_done[b] = 1'b0;
        repeat_at[b] = '0;
        return;
      end
      if (down[b]) begin
        if (mode_bit(two_stage_mask, b)) begin
          dt = now - press_at[b];
          if (!hold_done[b]) add_gesture(b, (dt >= long_press) ? G_LONG : G_SHORT, now);
        end else if (!long_done[b]) begin
          add_gesture(b, G_SHORT, now);
        end
      end
      down[b]      = 1'b0;
      long_done[b] = 1'b0;
      hold_done[b] = 1'b0;
    endfunction

    function void scan_tick(logic [31:0] now);
      logic [31:0] held_for, since_tap, since_repeat;
      for (int b = 0; b < N_BUTTONS; b++) begin
        held_for     = now - press_at[b];
        since_tap    = now - tap_at[b];
        since_repeat = now - repeat_at[b];
        if (mode_bit(double_hold_mask, b)) begin
          if (down[b] && !hold_done[b] && held_for >= hold_press) begin
            hold_done[b] = 1'b1;
            tap_open[b]  = 1'b0;
            add_gesture(b, G_HOLD, now);
          end
          if (tap_open[b] && since_tap > double_window) begin
            tap_open[b] = 1'b0;
            add_gesture(b, G_SHORT, now);
          end
        end else if (down[b]) begin
          if (mode_bit(two_stage_mask, b)) begin
            if (!hold_done[b] && held_for >= hold_press) begin
              hold_done[b] = 1'b1;
              add_gesture(b, G_HOLD, now);
            end
          end else if (!long_done[b]) begin
            if (held_for >= long_press) begin
              long_done[b] = 1'b1;
              repeat_at[b] = now;
              add_gesture(b, G_LONG, now);
            end
          end else if (since_repeat >= repeat_period) begin
            repeat_at[b] = now;
            add_gesture(b, G_REPEAT, now);
          end
        end
      end
    endfunction

    function void note_request(logic m, logic [2:0] b, logic k, logic [31:0] now);
      run_q.delete();
      requests++;
      if (m == MODE_TICK) begin
        ticks++;
        scan_tick(now);
      end else if (int'(b) < N_BUTTONS) begin
        press_edge(int'(b), k, now);
      end
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) pending_gestures.push_back(run_q[i]);
    endfunction

    function void check_gesture(logic [2:0] btn, logic [2:0] kind, logic [31:0] stamp,
                                logic last);
      gesture_rec_t want;
      if (pending_gestures.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected gesture: button %0d kind %0d stamp %h last %0b",
                   btn, kind, stamp, last);
        return;
      end
      want = pending_gestures.pop_front();
      checked++;
      kind_count[int'(want.kind)]++;
      if (btn !== want.button || kind !== want.kind || stamp !== want.stamp ||
          last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("Gesture mismatch: expected button %0d kind %0d stamp %h last %0b,",
                   want.button, want.kind, want.stamp, want.last);
          $display("  got button %0d kind %0d stamp %h last %0b",
                   btn, kind, stamp, last);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_stall;
  logic                  mode;
  logic [2:0]            button_id;
  logic                  key_pressed;
  logic [31:0]           timestamp;
  logic                  gesture_valid;
  logic                  gesture_stall;
  logic [2:0]            gesture_button;
  logic [2:0]            gesture_kind;
  logic [31:0]           event_stamp;
  logic                  last_of_run;

  gesture_scoreboard sb;
  bit                no_idle;
  logic              hold_off_req;
  bit                held[N_BUTTONS];
  logic [31:0]       clock_ms;

  button_gesture_detector_top #(
    .NUM_BUTTONS (N_BUTTONS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .button_id      (button_id),
    .key_pressed    (key_pressed),
    .timestamp      (timestamp),
    .gesture_valid  (gesture_valid),
    .gesture_stall  (gesture_stall),
    .gesture_button (gesture_button),
    .gesture_kind   (gesture_kind),
    .event_stamp    (event_stamp),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called at a rising edge; returns at the edge on which the request is taken.
  task automatic send_request(logic m, logic [2:0] b, logic k, logic [31:0] t);
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    mode        <= m;
    button_id   <= b;
    key_pressed <= k;
    timestamp   <= t;
    do @(posedge clk); while (item_stall);
    sb.note_request(m, b, k, t);
    if (m == MODE_EDGE) held[b] = k;
  endtask

  task automatic send_edge(int b, logic k, logic [31:0] t);
    send_request(MODE_EDGE, 3'(b), k, t);
  endtask

  // Button and key fields are ignored on a tick, so they carry random values.
  task automatic send_tick(logic [31:0] t);
    send_request(MODE_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), t);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] dw, logic [15:0] lp, logic [15:0] hp,
                           logic [15:0] rp, logic [7:0] dh, logic [7:0] ts);
    write_reg(REG_DOUBLE_WINDOW, dw);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_HOLD_PRESS, hp);
    write_reg(REG_REPEAT_PERIOD, rp);
    write_reg(REG_DOUBLE_HOLD, {8'h00, dh});
    write_reg(REG_TWO_STAGE, {8'h00, ts});
    cfg_valid <= 1'b0;
  endtask

  // A tick that gives nothing may still be scanning when the queue runs dry,
  // hence the extra cycles before any register write.
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.pending_gestures.size() != 0) @(posedge clk);
    repeat (2 * N_BUTTONS + 8) @(posedge clk);
  endtask

  // Mostly well-formed press and release pairs on a few nearby buttons with
  // time moving forward, mixed with ticks and some fully random requests.
  task automatic random_phase(int n, int unsigned step_max, int unsigned hot);
    int unsigned r;
    int unsigned b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), $urandom());
      end else begin
        clock_ms += $urandom_range(0, step_max);
        if (r < 52) begin
          send_tick(clock_ms);
        end else begin
          if ($urandom_range(0, 99) < 70) b = (hot + $urandom_range(0, 2)) % N_BUTTONS;
          else b = $urandom_range(0, N_BUTTONS - 1);
          if ($urandom_range(0, 99) < 88) send_edge(b, !held[b], clock_ms);
          else send_edge(b, 1'($urandom_range(0, 1)), clock_ms);
        end
      end
    end
  endtask

  initial begin : gesture_sink
    int unsigned hold_left;
    bit          hold_started;
    hold_left    = 0;
    hold_started = 1'b0;
    gesture_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && gesture_valid && !gesture_stall)
        sb.check_gesture(gesture_button, gesture_kind, event_stamp, last_of_run);
      if (hold_off_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        gesture_stall <= 1'b1;
      end else begin
        gesture_stall <= (!no_idle && $urandom_range(0, 99) < 14);
      end
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("Run timed out waiting for the block.");
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] base;
    sb = new();
    no_idle = 1'b0;
    foreach (held[b]) held[b] = 1'b0;
    rst          <= 1'b1;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    item_valid   <= 1'b0;
    mode         <= MODE_EDGE;
    button_id    <= '0;
    key_pressed  <= 1'b0;
    timestamp    <= '0;
    hold_off_req <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: buttons 0 and 1 double-hold, 2 and 3 two-stage, rest
    // normal. The time base sits just below the wrap so that it crosses zero.
    configure(16'd300, 16'd800, 16'd1500, 16'd200, 8'h03, 8'h0C);
    base = 32'hFFFF_FC00;
    send_edge(4, 1'b0, base);             // release with no press, normal button
    send_edge(0, 1'b0, base);             // release with no press, double-hold button
    send_edge(4, 1'b1, base);
    send_edge(4, 1'b1, base + 100);       // a second press restarts the timing
    send_tick(base + 899);
    send_tick(base + 900);                // Long
    send_tick(base + 1023);               // all-ones timestamp
    send_tick(base + 1100);               // Repeat across the wrap
    send_edge(4, 1'b0, base + 1150);      // no Short once Long has fired
    send_edge(0, 1'b1, base + 2000);
    send_edge(0, 1'b0, base + 2100);
    send_edge(0, 1'b1, base + 2400);      // Double right at the window edge
    send_edge(0, 1'b0, base + 2450);      // the eaten press leaves no tap
    send_edge(1, 1'b1, base + 3000);
    send_tick(base + 4500);               // Hold
    send_edge(1, 1'b0, base + 4600);
    send_edge(1, 1'b1, base + 5000);
    send_edge(1, 1'b0, base + 5050);
    send_tick(base + 5350);               // window not yet passed
    send_tick(base + 5351);               // deferred Short
    send_edge(2, 1'b1, base + 6000);
    send_edge(2, 1'b0, base + 6799);      // two-stage Short
    send_edge(3, 1'b1, base + 7000);
    send_edge(3, 1'b0, base + 7800);      // two-stage Long
    send_edge(2, 1'b1, base + 8000);
    send_tick(base + 9500);               // two-stage Hold
    send_edge(7, 1'b1, base + 9600);

    wait_drained();
    configure(16'd40, 16'd60, 16'd120, 16'd25, 8'($urandom()), 8'($urandom()));
    clock_ms = $urandom();
    random_phase(50, 30, 0);

    // All thresholds at zero: every held normal button gives Long on the first
    // tick and Repeat on each one after, so each tick yields a full run while
    // the output is held off and the block backs up into its input.
    wait_drained();
    configure(16'd0, 16'd0, 16'd0, 16'd0, 8'h00, 8'h00);
    no_idle = 1'b1;
    for (int b = 0; b < N_BUTTONS; b++) send_edge(b, 1'b1, clock_ms);
    hold_off_req <= 1'b1;
    for (int i = 0; i < 16; i++) begin
      clock_ms += 1;
      send_tick(clock_ms);
    end
    for (int b = 0; b < N_BUTTONS; b++) send_edge(b, 1'b0, clock_ms);
    no_idle = 1'b0;

    wait_drained();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    clock_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
    random_phase(30, 30000, 2);

    // The masks change while buttons may still be held; state carries over.
    wait_drained();
    configure(16'd50, 16'd90, 16'd150, 16'd20, 8'h00, 8'hFF);
    random_phase(20, 40, 4);
    wait_drained();
    configure(16'd50, 16'd90, 16'd150, 16'd20, 8'hF0, 8'h0F);
    random_phase(20, 40, 4);

    wait_drained();
    configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
              16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
              8'($urandom()), 8'($urandom()));
    random_phase(50, 120, $urandom_range(0, 7));

    item_valid <= 1'b0;
    while (sb.pending_gestures.size() != 0) @(posedge clk);
    repeat (2 * N_BUTTONS + 10) @(posedge clk);

    $display("Run covered %0d requests (%0d ticks) and checked %0d gestures.",
             sb.requests, sb.ticks, sb.checked);
    $display("Gestures seen: short %0d, long %0d, double %0d, hold %0d, repeat %0d.",
             sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
             sb.kind_count[4]);
    if (sb.pending_gestures.size() != 0)
      $display("%0d expected gestures never arrived.", sb.pending_gestures.size());
    if (sb.errors == 0 && sb.pending_gestures.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches in total.", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
